[rtl/wpre_pkg.sv]
`timescale 1ns / 1ps
// Package for the windowed peak/RMS envelope block: defaults, register
// indexes, controller states and the command/status structs. No dependencies.
package wpre_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RMS_ENABLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RMS_MIN_WINDOW = 2'd2;

  localparam int WINDOW_LEN_RST     = 1;
  localparam int RMS_MIN_WINDOW_RST = 44;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_LOAD
  } wpre_state_e;

  typedef struct packed {
    logic accept;
    logic arith_load;
    logic div_step;
    logic sqrt_step;
    logic out_load;
  } wpre_cmd_t;

  typedef struct packed {
    logic close;
    logic rms_ok;
    logic out_free;
  } wpre_stat_t;

endpackage

[rtl/wpre_lane.sv]
`timescale 1ns / 1ps
// One channel's arithmetic: restoring divide of the square sum by the window
// length, then a digit-by-digit square root of the quotient. Uses wpre_pkg.
module wpre_lane
  import wpre_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                                     clk_i,
  input  wpre_cmd_t                                cmd_i,
  input  logic [2*SAMPLE_BITS+COUNT_BITS-3:0]      dividend_i,
  input  logic [COUNT_BITS-1:0]                    divisor_i,
  output logic [(2*SAMPLE_BITS+COUNT_BITS-1)/2-1:0] root_o
);

  localparam int SUM_W  = 2 * SAMPLE_BITS + COUNT_BITS - 2;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int X_W    = 2 * ROOT_W;

  logic [X_W-1:0]        x_q, x_d;
  logic [COUNT_BITS-1:0] dvs_q;
  logic [COUNT_BITS-1:0] drem_q, drem_d;
  logic [ROOT_W-1:0]     srem_q, srem_d;
  logic [ROOT_W-1:0]     root_q, root_d;

  logic [COUNT_BITS:0]   d_cand;
  logic                  d_ge;
  logic [ROOT_W+1:0]     s_cand;
  logic [ROOT_W+1:0]     s_trial;
  logic                  s_ge;

  always_comb begin
    d_cand  = {drem_q, x_q[X_W-1]};
    d_ge    = d_cand >= {1'b0, dvs_q};
    s_cand  = {srem_q, x_q[X_W-1 -: 2]};
    s_trial = {root_q, 2'b01};
    s_ge    = s_cand >= s_trial;
    x_d     = x_q;
    drem_d  = drem_q;
    srem_d  = srem_q;
    root_d  = root_q;
    if (cmd_i.div_step) begin
      drem_d = d_ge ? COUNT_BITS'(d_cand - {1'b0, dvs_q}) : COUNT_BITS'(d_cand);
      x_d    = {x_q[X_W-2:0], d_ge};
    end else if (cmd_i.sqrt_step) begin
      srem_d = s_ge ? ROOT_W'(s_cand - s_trial) : ROOT_W'(s_cand);
      root_d = {root_q[ROOT_W-2:0], s_ge};
      x_d    = {x_q[X_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.arith_load) begin
      x_q    <= X_W'(dividend_i);
      dvs_q  <= divisor_i;
      drem_q <= '0;
      srem_q <= '0;
      root_q <= '0;
    end else begin
      x_q    <= x_d;
      drem_q <= drem_d;
      srem_q <= srem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

[rtl/wpre_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the envelope block: accumulate, divide, root and load
// sequence with its step counter. Uses wpre_pkg.
module wpre_ctrl
  import wpre_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  wpre_stat_t stat_i,
  output wpre_cmd_t  cmd_o
);

  localparam int SUM_W  = 2 * SAMPLE_BITS + COUNT_BITS - 2;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int X_W    = 2 * ROOT_W;
  localparam int CNT_W  = $clog2(X_W);

  wpre_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             div_done;
  logic             sqrt_done;

  assign div_done  = cnt_q == CNT_W'(X_W - 1);
  assign sqrt_done = cnt_q == CNT_W'(ROOT_W - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACCUM: begin
        if (in_valid_i && stat_i.close) begin
          state_d = stat_i.rms_ok ? ST_DIV : ST_LOAD;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) state_d = ST_ACCUM;
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cnt_d      = '0;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o       = 1'b1;
        cmd_o.accept     = in_valid_i;
        cmd_o.arith_load = in_valid_i && stat_i.close && stat_i.rms_ok;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = div_done ? '0 : CNT_W'(cnt_q + 1'b1);
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = sqrt_done ? '0 : CNT_W'(cnt_q + 1'b1);
      end
      ST_LOAD: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/wpre_dpath.sv]
`timescale 1ns / 1ps
// Datapath for the envelope block: configuration registers, min/max and
// square-sum accumulators, two arithmetic lanes, output register. Uses wpre_pkg.
module wpre_dpath
  import wpre_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [COUNT_BITS-1:0]         cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  logic                          end_of_data_i,
  input  wpre_cmd_t                     cmd_i,
  output wpre_stat_t                    stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_min_o,
  output logic signed [SAMPLE_BITS-1:0] left_max_o,
  output logic [SAMPLE_BITS-1:0]        left_rms_o,
  output logic signed [SAMPLE_BITS-1:0] right_min_o,
  output logic signed [SAMPLE_BITS-1:0] right_max_o,
  output logic [SAMPLE_BITS-1:0]        right_rms_o,
  output logic                          rms_valid_o,
  output logic                          final_column_o
);

  localparam int S      = SAMPLE_BITS;
  localparam int C      = COUNT_BITS;
  localparam int SUM_W  = 2 * S + C - 2;
  localparam int ROOT_W = (SUM_W + 1) / 2;

  localparam logic signed [S-1:0] SAMP_MAXV = {1'b0, {(S - 1){1'b1}}};
  localparam logic signed [S-1:0] SAMP_MINV = {1'b1, {(S - 1){1'b0}}};

  logic [C-1:0] win_len_q;
  logic         rms_en_q;
  logic [C-1:0] rms_min_q;

  logic signed [S-1:0] l_low_q, l_high_q, r_low_q, r_high_q;
  logic signed [S-1:0] l_low_d, l_high_d, r_low_d, r_high_d;
  logic [SUM_W-1:0]    l_sum_q, r_sum_q, l_sum_d, r_sum_d;
  logic [C-1:0]        fill_q, fill_d;
  logic signed [2*S-1:0] l_sq, r_sq;

  logic [C-1:0]      len;
  logic              last_q, valid_q;
  logic [ROOT_W-1:0] l_root, r_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= C'(WINDOW_LEN_RST);
      rms_en_q  <= 1'b0;
      rms_min_q <= C'(RMS_MIN_WINDOW_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LEN:     win_len_q <= cfg_data_i;
        REG_RMS_ENABLE:     rms_en_q  <= cfg_data_i[0];
        REG_RMS_MIN_WINDOW: rms_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    len      = (win_len_q == '0) ? C'(1) : win_len_q;
    l_sq     = left_sample_i * left_sample_i;
    r_sq     = right_sample_i * right_sample_i;
    l_low_d  = (left_sample_i < l_low_q) ? left_sample_i : l_low_q;
    l_high_d = (left_sample_i > l_high_q) ? left_sample_i : l_high_q;
    r_low_d  = (right_sample_i < r_low_q) ? right_sample_i : r_low_q;
    r_high_d = (right_sample_i > r_high_q) ? right_sample_i : r_high_q;
    l_sum_d  = SUM_W'(l_sum_q + SUM_W'($unsigned(l_sq)));
    r_sum_d  = SUM_W'(r_sum_q + SUM_W'($unsigned(r_sq)));
    fill_d   = C'(fill_q + C'(1));
    stat_o.close    = end_of_data_i || (fill_d >= len);
    stat_o.rms_ok   = rms_en_q && (len >= rms_min_q);
    stat_o.out_free = !out_valid_o || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_low_q  <= SAMP_MAXV;
      l_high_q <= SAMP_MINV;
      r_low_q  <= SAMP_MAXV;
      r_high_q <= SAMP_MINV;
      l_sum_q  <= '0;
      r_sum_q  <= '0;
      fill_q   <= '0;
    end else if (cmd_i.out_load) begin
      l_low_q  <= SAMP_MAXV;
      l_high_q <= SAMP_MINV;
      r_low_q  <= SAMP_MAXV;
      r_high_q <= SAMP_MINV;
      l_sum_q  <= '0;
      r_sum_q  <= '0;
      fill_q   <= '0;
    end else if (cmd_i.accept) begin
      l_low_q  <= l_low_d;
      l_high_q <= l_high_d;
      r_low_q  <= r_low_d;
      r_high_q <= r_high_d;
      l_sum_q  <= l_sum_d;
      r_sum_q  <= r_sum_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && stat_o.close) begin
      last_q  <= end_of_data_i;
      valid_q <= stat_o.rms_ok;
    end
  end

  wpre_lane #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_lane_left (
    .clk_i     (clk_i),
    .cmd_i     (cmd_i),
    .dividend_i(l_sum_d),
    .divisor_i (len),
    .root_o    (l_root)
  );

  wpre_lane #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_lane_right (
    .clk_i     (clk_i),
    .cmd_i     (cmd_i),
    .dividend_i(r_sum_d),
    .divisor_i (len),
    .root_o    (r_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      left_min_o     <= l_low_q;
      left_max_o     <= l_high_q;
      right_min_o    <= r_low_q;
      right_max_o    <= r_high_q;
      left_rms_o     <= valid_q ? l_root[S-1:0] : '0;
      right_rms_o    <= valid_q ? r_root[S-1:0] : '0;
      rms_valid_o    <= valid_q;
      final_column_o <= last_q;
    end
  end

endmodule

[rtl/windowed_peak_rms_envelope.sv]
`timescale 1ns / 1ps
// Top level of the windowed peak/RMS envelope block: controller plus datapath.
// Depends on wpre_pkg, wpre_ctrl, wpre_dpath and wpre_lane.
//
// Stereo frames are taken one per cycle while a window fills; each window of
// window_len frames (or a shorter one ended by end_of_data) yields one column
// of per-channel min, max and RMS. The frame that closes a window is followed
// by a stall of the input: only the load when RMS is not reported, otherwise
// 2*ceil((2*SAMPLE_BITS+COUNT_BITS-2)/2) divide steps, then half as many root
// steps, then the load, run by the bit-serial divider and square-root lanes,
// one per channel. A finished column sits in the output register while the
// next window fills; the load waits until that register is free.
module windowed_peak_rms_envelope
  import wpre_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [COUNT_BITS-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  logic                          end_of_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_min_o,
  output logic signed [SAMPLE_BITS-1:0] left_max_o,
  output logic [SAMPLE_BITS-1:0]        left_rms_o,
  output logic signed [SAMPLE_BITS-1:0] right_min_o,
  output logic signed [SAMPLE_BITS-1:0] right_max_o,
  output logic [SAMPLE_BITS-1:0]        right_rms_o,
  output logic                          rms_valid_o,
  output logic                          final_column_o
);

  wpre_cmd_t  cmd;
  wpre_stat_t stat;

  wpre_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  wpre_dpath #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .left_sample_i (left_sample_i),
    .right_sample_i(right_sample_i),
    .end_of_data_i (end_of_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_min_o    (left_min_o),
    .left_max_o    (left_max_o),
    .left_rms_o    (left_rms_o),
    .right_min_o   (right_min_o),
    .right_max_o   (right_max_o),
    .right_rms_o   (right_rms_o),
    .rms_valid_o   (rms_valid_o),
    .final_column_o(final_column_o)
  );

endmodule

[rtl/wpre_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the envelope block, bound to its top level.
// Depends on windowed_peak_rms_envelope.
module wpre_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          end_of_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] left_min_o,
  input logic signed [SAMPLE_BITS-1:0] left_max_o,
  input logic [SAMPLE_BITS-1:0]        left_rms_o,
  input logic signed [SAMPLE_BITS-1:0] right_min_o,
  input logic signed [SAMPLE_BITS-1:0] right_max_o,
  input logic [SAMPLE_BITS-1:0]        right_rms_o,
  input logic                          rms_valid_o,
  input logic                          final_column_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_min_o)
      && $stable(left_max_o) && $stable(left_rms_o) && $stable(right_rms_o)
      && $stable(rms_valid_o) && $stable(final_column_o))
    else $error("held column changed before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rms_valid_o |-> left_rms_o == '0 && right_rms_o == '0)
    else $error("rms nonzero while not reported");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_min_o <= left_max_o && right_min_o <= right_max_o)
    else $error("column min above max");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_data_i |=> !in_ready_o)
    else $error("input taken right after final frame");

endmodule

bind windowed_peak_rms_envelope wpre_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_wpre_checker (.*);

[sim/tb_windowed_peak_rms_envelope.sv]
`timescale 1ns / 1ps
// Testbench for windowed_peak_rms_envelope: directed and random stereo frames
// checked column by column against a predictor held in a small scoreboard class.
// Depends on wpre_pkg and the windowed_peak_rms_envelope RTL.
module tb_windowed_peak_rms_envelope;
  import wpre_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int CW = COUNT_BITS_DEF;
  localparam int SETTLE_CYCLES  = 100;
  localparam int IDLE_LIMIT     = 4000;
  localparam int RANDOM_FRAMES  = 1525;
  localparam int SQUEEZE_AT     = 300;
  localparam int SQUEEZE_CYCLES = 400;
  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] lmin;
    logic signed [SW-1:0] lmax;
    logic [SW-1:0]        lrms;
    logic signed [SW-1:0] rmin;
    logic signed [SW-1:0] rmax;
    logic [SW-1:0]        rrms;
    logic                 rms_ok;
    logic                 last;
  } column_t;

  class envelope_scoreboard;
    logic [CW-1:0] win_len;
    logic [CW-1:0] rms_floor;
    logic          rms_on;
    logic signed [SW-1:0] l_lo, l_hi, r_lo, r_hi;
    longint unsigned l_sq, r_sq;
    logic [CW-1:0] frames;
    column_t pending[$];
    int errors;
    int reports;

    function new();
      win_len   = CW'(WINDOW_LEN_RST);
      rms_on    = 1'b0;
      rms_floor = CW'(RMS_MIN_WINDOW_RST);
      errors    = 0;
      reports   = 0;
      restart();
    endfunction

    function void restart();
      l_lo   = SAMPLE_MAX;
      l_hi   = SAMPLE_MIN;
      r_lo   = SAMPLE_MAX;
      r_hi   = SAMPLE_MIN;
      l_sq   = 0;
      r_sq   = 0;
      frames = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
      case (idx)
        REG_WINDOW_LEN:     win_len = data;
        REG_RMS_ENABLE:     rms_on = data[0];
        REG_RMS_MIN_WINDOW: rms_floor = data;
        default: ;
      endcase
    endfunction

    static function logic [SW-1:0] root_floor(longint unsigned x);
      longint unsigned acc, trial;
      acc = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = acc | (64'd1 << b);
        if (trial * trial <= x) acc = trial;
      end
      return acc[SW-1:0];
    endfunction

    function void note_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r, logic eod);
      column_t c;
      longint ls, rs;
      longint unsigned len;
      ls = l;
      rs = r;
      if (l < l_lo) l_lo = l;
      if (l > l_hi) l_hi = l;
      if (r < r_lo) r_lo = r;
      if (r > r_hi) r_hi = r;
      l_sq += ls * ls;
      r_sq += rs * rs;
      frames = frames + 1'b1;
      len = (win_len == 0) ? 1 : win_len;
      if (!eod && frames < len) return;
      c.lmin   = l_lo;
      c.lmax   = l_hi;
      c.rmin   = r_lo;
      c.rmax   = r_hi;
      c.rms_ok = rms_on && (len >= rms_floor);
      c.lrms   = c.rms_ok ? root_floor(l_sq / len) : '0;
      c.rrms   = c.rms_ok ? root_floor(r_sq / len) : '0;
      c.last   = eod;
      pending.push_back(c);
      restart();
    endfunction

    function void compare(string tag, logic [SW-1:0] e, logic [SW-1:0] g);
      if (g !== e) begin
        errors++;
        if (reports < 10)
          $display("%0t mismatch on %s: expected %0h, got %0h", $time, tag, e, g);
        reports++;
      end
    endfunction

    function void check_column(column_t got);
      column_t want;
      if (pending.size() == 0) begin
        errors++;
        if (reports < 10) $display("%0t column transfer with nothing expected", $time);
        reports++;
        return;
      end
      want = pending.pop_front();
      compare("left_min", want.lmin, got.lmin);
      compare("left_max", want.lmax, got.lmax);
      compare("left_rms", want.lrms, got.lrms);
      compare("right_min", want.rmin, got.rmin);
      compare("right_max", want.rmax, got.rmax);
      compare("right_rms", want.rrms, got.rrms);
      compare("rms_valid", SW'(want.rms_ok), SW'(got.rms_ok));
      compare("final_column", SW'(want.last), SW'(got.last));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [SW-1:0] left_sample_i;
  logic signed [SW-1:0] right_sample_i;
  logic end_of_data_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SW-1:0] left_min_o;
  logic signed [SW-1:0] left_max_o;
  logic [SW-1:0] left_rms_o;
  logic signed [SW-1:0] right_min_o;
  logic signed [SW-1:0] right_max_o;
  logic [SW-1:0] right_rms_o;
  logic rms_valid_o;
  logic final_column_o;

  envelope_scoreboard sb;
  column_t seen_column;
  int n_sent;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit rx_calm;
  bit tx_calm;
  bit squeezed = 1'b0;

  windowed_peak_rms_envelope dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .end_of_data_i  (end_of_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_min_o     (left_min_o),
    .left_max_o     (left_max_o),
    .left_rms_o     (left_rms_o),
    .right_min_o    (right_min_o),
    .right_max_o    (right_max_o),
    .right_rms_o    (right_rms_o),
    .rms_valid_o    (rms_valid_o),
    .final_column_o (final_column_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return SW'($urandom_range(0, 64) - 32);
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_window(logic [CW-1:0] wl, logic en, logic [CW-1:0] mw);
    cfg_write(REG_WINDOW_LEN, wl);
    cfg_write(REG_RMS_ENABLE, {{(CW-1){1'b0}}, en});
    cfg_write(REG_RMS_MIN_WINDOW, mw);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r, logic eod);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    end_of_data_i  <= eod;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_frame(l, r, eod);
    n_sent++;
    @(negedge clk_i);
  endtask

  // drop valid, drain every column, then let the divider settle
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!squeezed && n_sent >= SQUEEZE_AT) begin
      squeezed = 1'b1;
      rx_hold = SQUEEZE_CYCLES;
      out_ready_i <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      rx_hold = rx_calm ? 0 : pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_column = '{left_min_o, left_max_o, left_rms_o, right_min_o, right_max_o,
                      right_rms_o, rms_valid_o, final_column_o};
      sb.check_column(seen_column);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_windowed_peak_rms_envelope: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int wl, mw, nf;
    logic en, eod;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    left_sample_i = '0;
    right_sample_i = '0;
    end_of_data_i = 1'b0;
    n_sent = 0;
    rx_calm = 1'b0;
    tx_calm = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings, one frame per column, peak extremes
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    finish_phase();

    // full window on the final frame, then a partial final window
    set_window(4, 1'b1, 0);
    send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_frame(0, 0, 1'b0);
    send_frame(-1, 1, 1'b1);
    send_frame(1, -1, 1'b0);
    send_frame(2, -2, 1'b1);
    finish_phase();

    // zero window length acts as one
    set_window(0, 1'b1, 1);
    send_frame(12345, -12345, 1'b0);
    send_frame(-1, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MAX, 0, 1'b1);
    finish_phase();

    // longest window, flushed early
    set_window(16'hFFFF, 1'b1, 16'hFFFF);
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_frame(100, -100, 1'b1);
    finish_phase();

    // lower the window length below the frames already taken
    set_window(50, 1'b1, 50);
    repeat (10) send_frame(pick_sample(), pick_sample(), 1'b0);
    finish_phase();
    set_window(5, 1'b1, 50);
    send_frame(7, -7, 1'b0);
    finish_phase();

    while (n_sent < RANDOM_FRAMES) begin
      case ($urandom_range(0, 19))
        0: wl = 0;
        1: wl = 65535;
        2, 3, 4: wl = $urandom_range(9, 64);
        default: wl = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 7))
        0: mw = 0;
        1: mw = wl;
        2: mw = (wl + 1) & 16'hFFFF;
        3: mw = 44;
        4: mw = 65535;
        default: mw = $urandom_range(0, 10);
      endcase
      en = ($urandom_range(0, 3) != 0);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      set_window(CW'(wl), en, CW'(mw));
      nf = (wl > 64) ? $urandom_range(2, 6) : $urandom_range(10, 50);
      for (int i = 0; i < nf; i++) begin
        if (i == nf - 1) eod = (wl > 64) || ($urandom_range(0, 1) == 1);
        else eod = ($urandom_range(0, 24) == 0);
        send_frame(pick_sample(), pick_sample(), eod);
      end
      finish_phase();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_windowed_peak_rms_envelope: done, clean");
    end else begin
      $display("tb_windowed_peak_rms_envelope: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/wpre_pkg.sv
rtl/wpre_lane.sv
rtl/wpre_ctrl.sv
rtl/wpre_dpath.sv
rtl/windowed_peak_rms_envelope.sv
rtl/wpre_checker.sv
sim/tb_windowed_peak_rms_envelope.sv
